>>> rtl/core/kwe_pkg.sv
// ----------------------------------------------------------------------------
// kwe_pkg: shared types and constants for the k-mer window encoder
// Holds the field widths, the nucleotide code table and the control word
// that steers the row of window cells.
// ----------------------------------------------------------------------------
package kwe_pkg;

	localparam int unsigned NIB_W    = 4;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned KLEN_W   = 5;
	localparam int unsigned POS_W    = 32;
	localparam int unsigned WORD_W   = 64;
	localparam int unsigned S_DATA_W = 8;
	localparam int unsigned S_USER_W = 1;
	localparam int unsigned M_DATA_W = 104;
	localparam int unsigned M_USER_W = 2;

	localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd16;

	// Nucleotide codes; zero marks a character outside the alphabet
	localparam logic [NIB_W-1:0] CODE_NONE = 4'h0;
	localparam logic [NIB_W-1:0] CODE_A    = 4'h1;
	localparam logic [NIB_W-1:0] CODE_T    = 4'h2;
	localparam logic [NIB_W-1:0] CODE_G    = 4'h3;
	localparam logic [NIB_W-1:0] CODE_C    = 4'h4;
	localparam logic [NIB_W-1:0] CODE_W    = 4'h5;
	localparam logic [NIB_W-1:0] CODE_S    = 4'h6;
	localparam logic [NIB_W-1:0] CODE_M    = 4'h7;
	localparam logic [NIB_W-1:0] CODE_K    = 4'h8;
	localparam logic [NIB_W-1:0] CODE_R    = 4'h9;
	localparam logic [NIB_W-1:0] CODE_Y    = 4'hA;
	localparam logic [NIB_W-1:0] CODE_B    = 4'hB;
	localparam logic [NIB_W-1:0] CODE_D    = 4'hC;
	localparam logic [NIB_W-1:0] CODE_H    = 4'hD;
	localparam logic [NIB_W-1:0] CODE_V    = 4'hE;
	localparam logic [NIB_W-1:0] CODE_N    = 4'hF;

	// Control word broadcast along the cell row
	typedef struct packed {
		logic load;   // a word is accepted this cycle
		logic clear;  // start of a new sequence
		logic shift;  // a valid base enters the window
	} kwe_ctrl_t;

	function automatic logic [NIB_W-1:0] iupac_code(input logic [CHAR_W-1:0] ch);
		logic [NIB_W-1:0] code;
		unique case (ch)
			8'h41: code = CODE_A;
			8'h54: code = CODE_T;
			8'h47: code = CODE_G;
			8'h43: code = CODE_C;
			8'h57: code = CODE_W;
			8'h53: code = CODE_S;
			8'h4D: code = CODE_M;
			8'h4B: code = CODE_K;
			8'h52: code = CODE_R;
			8'h59: code = CODE_Y;
			8'h42: code = CODE_B;
			8'h44: code = CODE_D;
			8'h48: code = CODE_H;
			8'h56: code = CODE_V;
			8'h4E: code = CODE_N;
			default: code = CODE_NONE;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/core/kwe_cell.sv
// ----------------------------------------------------------------------------
// kwe_cell: one nibble of the rolling k-mer window
// Holds one base code, takes its neighbour's code on a shift and shows its
// next value when it lies inside the selected window length.
// ----------------------------------------------------------------------------
module kwe_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kwe_pkg::kwe_ctrl_t            ctrl,
	input  logic [kwe_pkg::KLEN_W-1:0]    klen,
	input  logic [kwe_pkg::NIB_W-1:0]     din,
	output logic [kwe_pkg::NIB_W-1:0]     nib,
	output logic [kwe_pkg::NIB_W-1:0]     view
);

	logic [kwe_pkg::NIB_W-1:0] nib_q;
	logic [kwe_pkg::NIB_W-1:0] din_eff;
	logic [kwe_pkg::NIB_W-1:0] nib_d;

	// the first cell takes the fresh code; the rest drop what a start clears
	always_comb begin
		if (INDEX == 0) begin
			din_eff = din;
		end else begin
			din_eff = ctrl.clear ? '0 : din;
		end
		if (ctrl.shift) begin
			nib_d = din_eff;
		end else begin
			nib_d = ctrl.clear ? '0 : nib_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nib_q <= '0;
		end else if (ctrl.load) begin
			nib_q <= nib_d;
		end
	end

	assign nib  = nib_q;
	assign view = (klen > kwe_pkg::KLEN_W'(INDEX)) ? nib_d : '0;

endmodule

>>> rtl/core/kmer_window_encoder.sv
// ----------------------------------------------------------------------------
// kmer_window_encoder: rolling IUPAC k-mer packer
// One ASCII nucleotide per input word, one packed k-mer per output word.
// ----------------------------------------------------------------------------
// Each accepted character is mapped to a 4-bit IUPAC code (A=1, T=2, G=3,
// C=4, W..N=5..15) and shifted into a row of MAX_KMER nibble cells, newest
// base in the low nibble; the output shows the lowest kmer_len cells, zero
// above. A set start flag in tuser clears the window, the fill count and the
// position before the character is taken. A character outside the upper-case
// IUPAC alphabet leaves the window untouched and comes back as bad_base with
// the character and its position. The block takes one word every cycle
// unless the output register is full and not drained: the cell shift, the
// lookup and the fill count settle combinationally, and a single output
// register holds the result, shown in the cycle after its word is taken.
// The user must write kmer_len over the cfg channel only while the stream
// is idle (the block does not enforce it); 0 reads as 1, >MAX_KMER as MAX_KMER.
// ----------------------------------------------------------------------------
module kmer_window_encoder #(
	parameter int unsigned MAX_KMER = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: kmer_len
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kwe_pkg::KLEN_W-1:0]      cfg_data,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [kwe_pkg::S_DATA_W-1:0]    s_axis_tdata,  // [7:0] base_char
	input  logic [kwe_pkg::S_USER_W-1:0]    s_axis_tuser,  // [0] start_sequence
	// output stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [63:0] kmer_word, [71:64] rejected_char, [103:72] base_position
	output logic [kwe_pkg::M_DATA_W-1:0]    m_axis_tdata,
	// [0] kmer_full, [1] bad_base
	output logic [kwe_pkg::M_USER_W-1:0]    m_axis_tuser
);

	localparam int unsigned FILL_W = $clog2(MAX_KMER + 1);
	localparam int unsigned VIEW_W = kwe_pkg::NIB_W * MAX_KMER;

	logic [kwe_pkg::KLEN_W-1:0]  kmer_len_q;
	logic [kwe_pkg::KLEN_W-1:0]  klen_eff;
	logic [FILL_W-1:0]           fill_q;
	logic [FILL_W-1:0]           fill_base;
	logic [FILL_W-1:0]           fill_d;
	logic [kwe_pkg::POS_W-1:0]   pos_q;
	logic [kwe_pkg::POS_W-1:0]   pos_cur;
	logic                        accept;
	logic                        start;
	logic [kwe_pkg::CHAR_W-1:0]  ch;
	logic [kwe_pkg::NIB_W-1:0]   code;
	logic                        bad;
	logic                        full;
	kwe_pkg::kwe_ctrl_t          ctrl;
	logic [kwe_pkg::NIB_W-1:0]   link [MAX_KMER+1];
	logic [VIEW_W-1:0]           view;

	logic                        m_valid_q;
	logic [kwe_pkg::M_DATA_W-1:0] m_data_q;
	logic [kwe_pkg::M_USER_W-1:0] m_user_q;

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q <= kwe_pkg::KLEN_RESET;
		end else if (cfg_valid) begin
			kmer_len_q <= cfg_data;
		end
	end

	// clamp the window length to 1..MAX_KMER
	always_comb begin
		if (kmer_len_q == '0) begin
			klen_eff = kwe_pkg::KLEN_W'(1);
		end else if (kmer_len_q > kwe_pkg::KLEN_W'(MAX_KMER)) begin
			klen_eff = kwe_pkg::KLEN_W'(MAX_KMER);
		end else begin
			klen_eff = kmer_len_q;
		end
	end

	// accept whenever the output register is free or drains this cycle
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign ch            = s_axis_tdata[kwe_pkg::CHAR_W-1:0];
	assign start         = s_axis_tuser[0];
	assign code          = kwe_pkg::iupac_code(ch);
	assign bad           = (code == kwe_pkg::CODE_NONE);

	assign ctrl.load  = accept;
	assign ctrl.clear = start;
	assign ctrl.shift = !bad;

	// the row of cells: each takes the code held by its lower neighbour
	assign link[0] = code;

	for (genvar i = 0; i < MAX_KMER; i++) begin : g_cell
		kwe_cell #(
			.INDEX (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.klen   (klen_eff),
			.din    (link[i]),
			.nib    (link[i+1]),
			.view   (view[kwe_pkg::NIB_W*i +: kwe_pkg::NIB_W])
		);
	end

	// fill count saturates at MAX_KMER; position wraps
	always_comb begin
		fill_base = start ? '0 : fill_q;
		fill_d    = fill_base;
		if (!bad && (fill_base != FILL_W'(MAX_KMER))) begin
			fill_d = fill_base + FILL_W'(1);
		end
		pos_cur = start ? '0 : pos_q;
		full    = (kwe_pkg::KLEN_W'(fill_d) >= klen_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
		end else if (accept) begin
			fill_q <= fill_d;
			pos_q  <= pos_cur + kwe_pkg::POS_W'(1);
		end
	end

	// output register: hold until taken, load on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {pos_cur, (bad ? ch : kwe_pkg::CHAR_W'(0)),
			             kwe_pkg::WORD_W'(view)};
			m_user_q <= {bad, full};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// fill count never passes the window depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_KMER))
		else $error("fill count beyond window depth");

	// a start word restarts the position count at one
	a_start_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept && start |=> pos_q == kwe_pkg::POS_W'(1))
		else $error("position not restarted by start");

	// a rejected character leaves the fill count untouched
	a_bad_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && bad && !start |=> fill_q == $past(fill_q))
		else $error("fill count moved on a bad character");

	// a good character reports no rejected character
	a_clean_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_user_q[1] |-> m_data_q[71:64] == '0)
		else $error("rejected character shown on a good base");

endmodule

>>> bench/kwe_tb_pkg.sv
// ----------------------------------------------------------------------------
// kwe_tb_pkg: k-mer scoreboard for the window encoder bench
// Predicts the packed k-mer, fill flag, rejected character and position for
// each accepted character, and checks the output words in order.
// ----------------------------------------------------------------------------
package kwe_tb_pkg;

	import kwe_pkg::*;

	// Valid upper-case letters, in code order: the code is index plus one
	localparam string NUCLEOTIDES = "ATGCWSMKRYBDHVN";
	localparam int unsigned MAX_BASES = 16;

	typedef struct {
		logic [WORD_W-1:0] kmer_word;
		logic              kmer_full;
		logic              bad_base;
		logic [CHAR_W-1:0] rejected_char;
		logic [POS_W-1:0]  base_position;
	} kmer_result_t;

	class kmer_scoreboard;
		logic [WORD_W-1:0] window;
		int unsigned       fill;
		logic [POS_W-1:0]  position;
		logic [KLEN_W-1:0] kmer_len;
		kmer_result_t      expected_kmers[$];
		int unsigned       mismatches;

		function new();
			window = '0;
			fill = 0;
			position = '0;
			kmer_len = KLEN_RESET;
			mismatches = 0;
		endfunction

		function void set_kmer_len(logic [KLEN_W-1:0] len);
			kmer_len = len;
		endfunction

		function int unsigned pending();
			return expected_kmers.size();
		endfunction

		// Advance the window by one accepted character and queue its result
		function void note_base(logic [CHAR_W-1:0] ch, logic start);
			kmer_result_t r;
			logic [NIB_W-1:0] code;
			logic [WORD_W-1:0] mask;
			int unsigned k;
			if (start) begin
				window = '0;
				fill = 0;
				position = '0;
			end
			r.base_position = position;
			position = position + 1;
			code = '0;
			for (int i = 0; i < NUCLEOTIDES.len(); i++) begin
				if (NUCLEOTIDES[i] == ch)
					code = NIB_W'(i + 1);
			end
			if (code != '0) begin
				window = {window[WORD_W-NIB_W-1:0], code};
				if (fill < MAX_BASES)
					fill++;
			end
			k = (kmer_len == 0) ? 1 : (kmer_len > MAX_BASES) ? MAX_BASES : kmer_len;
			mask = (k == MAX_BASES) ? '1 : ((WORD_W'(1) << (NIB_W * k)) - 1);
			r.kmer_word = window & mask;
			r.kmer_full = (fill >= k);
			r.bad_base = (code == '0);
			r.rejected_char = (code == '0) ? ch : '0;
			expected_kmers.push_back(r);
		endfunction

		// Compare one output word against the oldest expected k-mer
		function void check_word(logic [M_DATA_W-1:0] tdata, logic [M_USER_W-1:0] tuser);
			kmer_result_t e;
			if (expected_kmers.size() == 0) begin
				$error("output word with nothing expected: tdata=%h tuser=%b", tdata, tuser);
				mismatches++;
				return;
			end
			e = expected_kmers.pop_front();
			if (tdata[63:0] !== e.kmer_word) begin
				$error("kmer_word: expected %h, got %h", e.kmer_word, tdata[63:0]);
				mismatches++;
			end
			if (tdata[71:64] !== e.rejected_char) begin
				$error("rejected_char: expected %h, got %h", e.rejected_char, tdata[71:64]);
				mismatches++;
			end
			if (tdata[103:72] !== e.base_position) begin
				$error("base_position: expected %0d, got %0d", e.base_position,
					tdata[103:72]);
				mismatches++;
			end
			if (tuser[0] !== e.kmer_full) begin
				$error("kmer_full: expected %b, got %b", e.kmer_full, tuser[0]);
				mismatches++;
			end
			if (tuser[1] !== e.bad_base) begin
				$error("bad_base: expected %b, got %b", e.bad_base, tuser[1]);
				mismatches++;
			end
		endfunction
	endclass

endpackage

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: stream bench for the k-mer window encoder
// Feeds directed and random characters through the input stream, writes
// kmer_len between phases (extremes, zero and out-of-range values among them)
// and checks every output word against a scoreboard prediction, with random
// back-pressure and gaps on both sides.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import kwe_pkg::*;
	import kwe_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned WORDS_PER_PHASE = 50;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [KLEN_W-1:0]   cfg_data = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;    // [7:0] base_char
	logic [S_USER_W-1:0] s_axis_tuser = '0;    // [0] start_sequence
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;         // [63:0] kmer_word, [71:64] rejected_char,
	                                           // [103:72] base_position
	logic [M_USER_W-1:0] m_axis_tuser;         // [0] kmer_full, [1] bad_base

	// Chance, in percent, that the sender or the receiver idles in a cycle
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned cycle_count = 0;

	kmer_scoreboard kmers = new();

	kmer_window_encoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver back-pressure: pick ready afresh on every falling edge
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: note accepted characters first, so that a word leaving at the
	// same edge is still matched against the older expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				kmers.note_base(s_axis_tdata, s_axis_tuser[0]);
			if (m_axis_tvalid && m_axis_tready)
				kmers.check_word(m_axis_tdata, m_axis_tuser);
		end
	end

	// Offer one character; entered and left on a falling edge. Valid is left
	// high on return so that back-to-back words need no lowering in between.
	task automatic send_base(input logic [CHAR_W-1:0] ch, input logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tuser <= start;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold the sender off until every expected word has come back
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		while (kmers.pending() != 0)
			@(negedge clk);
	endtask

	// Write kmer_len with the stream idle; the output register is drained by
	// the time the queue empties.
	task automatic write_kmer_len(input logic [KLEN_W-1:0] len);
		hold_until_drained();
		repeat (2) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		kmers.set_kmer_len(len);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [KLEN_W-1:0] phase_len[8];
		logic [CHAR_W-1:0] ch;
		int unsigned pick;

		// Sequence of window lengths: small, the minimum, zero (reads as one),
		// the maximum code, just above the maximum, the maximum, eight, then random
		phase_len = '{5'd3, 5'd1, 5'd0, 5'd31, 5'd17, 5'd16, 5'd8, 5'd0};
		phase_len[7] = KLEN_W'($urandom_range(31));

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset length of sixteen
		send_idle_pct = 23;
		recv_idle_pct = 48;
		send_base("A", 1'b1);
		for (int i = 1; i < NUCLEOTIDES.len(); i++)
			send_base(NUCLEOTIDES[i], 1'b0);
		send_base("a", 1'b0);       // lower case is rejected
		send_base(8'h00, 1'b0);
		send_base(8'hFF, 1'b0);
		send_base("A", 1'b0);       // sixteenth valid base: window full
		send_base("N", 1'b0);       // oldest base drops out
		send_base(8'h7F, 1'b1);     // start on a rejected character
		send_base("@", 1'b0);       // neighbours of the alphabet
		send_base("Z", 1'b0);
		send_base("G", 1'b0);

		// Random phases; the first three with a slow receiver, the next three
		// with a slow sender, the last two at full rate
		for (int p = 0; p < 8; p++) begin
			write_kmer_len(phase_len[p]);
			send_idle_pct = (p < 3) ? 23 : (p < 6) ? 48 : 0;
			recv_idle_pct = (p < 3) ? 48 : (p < 6) ? 23 : 0;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if (p == 1 && n == WORDS_PER_PHASE / 2)
					hold_until_drained();
				pick = $urandom_range(99);
				if (pick < 85)
					ch = NUCLEOTIDES[$urandom_range(NUCLEOTIDES.len() - 1)];
				else if (pick < 92)
					ch = CHAR_W'($urandom_range(8'h7A, 8'h61));
				else
					ch = CHAR_W'($urandom_range(255));
				send_base(ch, (n == 0) || ($urandom_range(24) == 0));
			end
		end

		hold_until_drained();
		repeat (4) @(posedge clk);
		if (kmers.mismatches == 0 && kmers.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/kwe_pkg.sv
rtl/core/kwe_cell.sv
rtl/core/kmer_window_encoder.sv
bench/kwe_tb_pkg.sv
bench/tb.sv
